// ----- rtl/crcfpr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcfpr_pkg
// Types and constants shared by the framed packet receiver modules.
// ----------------------------------------------------------------------------
package crcfpr_pkg;

  // Frame markers and CRC-16/Modbus constants
  localparam logic [7:0]  START_MARK     = 8'hAA;
  localparam logic [7:0]  END_MARK       = 8'h55;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam int          FRAME_OVERHEAD = 7;

  // Byte position counter, saturating
  localparam int          POS_W   = 17;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Header byte positions
  localparam logic [POS_W-1:0] POS_START   = 17'd0;
  localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd1;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd2;
  localparam logic [POS_W-1:0] POS_COMMAND = 17'd3;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 17'd4;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes
  localparam logic [1:0] VERDICT_GOOD    = 2'd0;
  localparam logic [1:0] VERDICT_FRAMING = 2'd1;
  localparam logic [1:0] VERDICT_LENGTH  = 2'd2;
  localparam logic [1:0] VERDICT_CRC     = 2'd3;

  // Input beat
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } rx_beat_t;

  // Result beat
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  command;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] payload_length;
    logic [1:0]  verdict;
  } result_t;

  // Parser status toward the pipeline control
  typedef struct packed {
    logic    hit;
    result_t result;
  } parse_out_t;

endpackage
`default_nettype wire

// ----- rtl/crcfpr_crc16.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcfpr_crc16
// One-byte CRC-16/Modbus update, reflected, eight bit steps unrolled.
// ----------------------------------------------------------------------------
module crcfpr_crc16 (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_out
);

  // Bit-serial LFSR steps, LSB first
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ crcfpr_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule
`default_nettype wire

// ----- rtl/crcfpr_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcfpr_parser
// Frame parse state and per-byte decode: header capture, CRC accumulation,
// payload emit and end-of-buffer verdict.
// ----------------------------------------------------------------------------
module crcfpr_parser (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire crcfpr_pkg::rx_beat_t   beat,
  output crcfpr_pkg::parse_out_t      status
);

  localparam int POS_W = crcfpr_pkg::POS_W;

  logic [POS_W-1:0] byte_position;
  logic             start_good;
  logic [15:0]      header_length;
  logic [7:0]       frame_command;
  logic [15:0]      running_crc;
  logic [15:0]      received_crc;

  logic             start_good_next;
  logic [15:0]      header_length_next;
  logic [7:0]       frame_command_next;
  logic [15:0]      running_crc_next;
  logic [15:0]      received_crc_next;
  logic [POS_W-1:0] byte_position_next;

  logic [15:0]      crc_folded;
  logic [POS_W-1:0] pay_off;
  logic             is_payload;
  logic [POS_W:0]   total;
  logic [POS_W:0]   expect_total;
  logic [1:0]       verdict;

  crcfpr_crc16 u_crc (
    .crc_in  (running_crc),
    .data    (beat.rx_byte),
    .crc_out (crc_folded)
  );

  // Field capture by byte position
  always_comb begin
    start_good_next    = start_good;
    header_length_next = header_length;
    frame_command_next = frame_command;
    running_crc_next   = running_crc;
    received_crc_next  = {received_crc[7:0], beat.rx_byte};
    pay_off            = byte_position - crcfpr_pkg::POS_PAYLOAD;
    is_payload         = 1'b0;
    if (byte_position == crcfpr_pkg::POS_START) begin
      start_good_next = (beat.rx_byte == crcfpr_pkg::START_MARK);
    end else if (byte_position == crcfpr_pkg::POS_LEN_HI) begin
      header_length_next = {beat.rx_byte, header_length[7:0]};
      running_crc_next   = crc_folded;
    end else if (byte_position == crcfpr_pkg::POS_LEN_LO) begin
      header_length_next = {header_length[15:8], beat.rx_byte};
      running_crc_next   = crc_folded;
    end else if (byte_position == crcfpr_pkg::POS_COMMAND) begin
      frame_command_next = beat.rx_byte;
      running_crc_next   = crc_folded;
    end else if (pay_off < {1'b0, header_length}) begin
      running_crc_next = crc_folded;
      is_payload       = 1'b1;
    end
  end

  // Verdict on the buffer's last byte
  always_comb begin
    total        = {1'b0, byte_position} + 18'd1;
    expect_total = 18'(crcfpr_pkg::FRAME_OVERHEAD) + {2'b00, header_length_next};
    if (total < 18'(crcfpr_pkg::FRAME_OVERHEAD) || !start_good_next ||
        beat.rx_byte != crcfpr_pkg::END_MARK) begin
      verdict = crcfpr_pkg::VERDICT_FRAMING;
    end else if (total != expect_total) begin
      verdict = crcfpr_pkg::VERDICT_LENGTH;
    end else if (received_crc != running_crc_next) begin
      verdict = crcfpr_pkg::VERDICT_CRC;
    end else begin
      verdict = crcfpr_pkg::VERDICT_GOOD;
    end
  end

  // Result beat
  always_comb begin
    status.hit                   = beat.buffer_end || is_payload;
    status.result.command        = frame_command_next;
    status.result.payload_length = header_length_next;
    if (beat.buffer_end) begin
      status.result.result_kind   = crcfpr_pkg::KIND_VERDICT;
      status.result.payload_byte  = 8'h00;
      status.result.payload_index = 16'h0000;
      status.result.verdict       = verdict;
    end else begin
      status.result.result_kind   = crcfpr_pkg::KIND_PAYLOAD;
      status.result.payload_byte  = beat.rx_byte;
      status.result.payload_index = pay_off[15:0];
      status.result.verdict       = crcfpr_pkg::VERDICT_GOOD;
    end
  end

  // Saturating position count
  assign byte_position_next = (byte_position == crcfpr_pkg::POS_MAX) ?
                              byte_position : byte_position + 17'd1;

  // State update; the last byte returns everything to reset values
  always_ff @(posedge clk) begin
    if (rst || (step && beat.buffer_end)) begin
      byte_position <= '0;
      start_good    <= 1'b0;
      header_length <= 16'h0000;
      frame_command <= 8'h00;
      running_crc   <= crcfpr_pkg::CRC_INIT;
      received_crc  <= 16'h0000;
    end else if (step) begin
      byte_position <= byte_position_next;
      start_good    <= start_good_next;
      header_length <= header_length_next;
      frame_command <= frame_command_next;
      running_crc   <= running_crc_next;
      received_crc  <= received_crc_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/crc_framed_packet_receiver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Data path: a byte accepted into the input register is parsed combinationally
// into the result register, from which its result beat is taken.
// Throughput: one byte per cycle, set by the combinational parse step between
// the two registers; stalls only while the result register is held.
// Reset: synchronous; parse state returns to start of buffer, CRC to 0xFFFF.
// ----------------------------------------------------------------------------
// crc_framed_packet_receiver
// Deframes 0xAA/length/command/payload/CRC-16 Modbus/0x55 receive buffers,
// streaming payload bytes and giving one verdict per buffer.
// ----------------------------------------------------------------------------
module crc_framed_packet_receiver (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rx_valid,
  output logic                      rx_ready,
  input  wire crcfpr_pkg::rx_beat_t rx_data,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output crcfpr_pkg::result_t       res_data
);

  logic                   in_valid;
  crcfpr_pkg::rx_beat_t   in_beat;
  logic                   advance;
  crcfpr_pkg::parse_out_t status;

  // Parse when a beat is held and the result slot is empty or being taken
  assign advance  = in_valid && (!res_valid || res_ready);
  assign rx_ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx_ready) begin
      in_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      in_beat <= rx_data;
    end
  end

  crcfpr_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .beat   (in_beat),
    .status (status)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= status.hit;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && status.hit) begin
      res_data <= status.result;
    end
  end

  // Checks
  a_verdict_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.result_kind == crcfpr_pkg::KIND_VERDICT |->
      res_data.payload_byte == 8'h00 && res_data.payload_index == 16'h0000)
    else $error("verdict beat carries payload fields");

  a_payload_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.result_kind == crcfpr_pkg::KIND_PAYLOAD |->
      res_data.payload_index < res_data.payload_length &&
      res_data.verdict == crcfpr_pkg::VERDICT_GOOD)
    else $error("payload beat outside header length");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> rx_ready)
    else $error("empty input register refuses a beat");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("held result dropped");

endmodule
`default_nettype wire

// ----- verif/tb_crc_framed_packet_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc_framed_packet_receiver
// Self-checking bench for the framed packet receiver. Receive buffers, either
// well formed or damaged on purpose, are pushed through the rx channel while
// the result channel stalls at random. A parser model inside the bench
// predicts every payload beat and verdict, and a checker compares each
// result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_crc_framed_packet_receiver;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 40;

  logic                 clk;
  logic                 rst;
  logic                 rx_valid;
  logic                 rx_ready;
  crcfpr_pkg::rx_beat_t rx_data;
  logic                 res_valid;
  logic                 res_ready;
  crcfpr_pkg::result_t  res_data;

  crc_framed_packet_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_data   (rx_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // Parser model state
  logic [crcfpr_pkg::POS_W-1:0] pos_q;
  logic                         start_ok;
  logic [15:0]                  hdr_len;
  logic [7:0]                   hdr_cmd;
  logic [15:0]                  crc_acc;
  logic [15:0]                  tail_crc;

  crcfpr_pkg::result_t pending_results[$];
  logic [7:0]          frame_bytes[$];

  bit idle_en;
  bit stall_en;
  int hold_len;
  int errors;
  int sent_items;
  int quiet_cycles;

  // Clock: 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // One CRC-16/Modbus byte update, reflected
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ crcfpr_pkg::CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  task automatic clear_parser();
    pos_q    = '0;
    start_ok = 1'b0;
    hdr_len  = '0;
    hdr_cmd  = '0;
    crc_acc  = crcfpr_pkg::CRC_INIT;
    tail_crc = '0;
  endtask

  // Advance the parser model by one accepted byte, queue any result
  task automatic predict_beat(input logic [7:0] b, input logic last);
    crcfpr_pkg::result_t r;
    logic [15:0]         tail_prev;
    logic                is_pay;
    int                  total;
    tail_prev = tail_crc;
    is_pay    = 1'b0;
    if (pos_q == crcfpr_pkg::POS_START) begin
      start_ok = (b == crcfpr_pkg::START_MARK);
    end else if (pos_q == crcfpr_pkg::POS_LEN_HI) begin
      hdr_len[15:8] = b;
      crc_acc = crc16_step(crc_acc, b);
    end else if (pos_q == crcfpr_pkg::POS_LEN_LO) begin
      hdr_len[7:0] = b;
      crc_acc = crc16_step(crc_acc, b);
    end else if (pos_q == crcfpr_pkg::POS_COMMAND) begin
      hdr_cmd = b;
      crc_acc = crc16_step(crc_acc, b);
    end else if (int'(pos_q) - int'(crcfpr_pkg::POS_PAYLOAD) < int'(hdr_len)) begin
      crc_acc = crc16_step(crc_acc, b);
      is_pay  = 1'b1;
    end
    tail_crc = {tail_crc[7:0], b};

    r = '0;
    if (last) begin
      total = int'(pos_q) + 1;
      r.result_kind    = crcfpr_pkg::KIND_VERDICT;
      r.command        = hdr_cmd;
      r.payload_length = hdr_len;
      if (total < crcfpr_pkg::FRAME_OVERHEAD || !start_ok || b != crcfpr_pkg::END_MARK)
        r.verdict = crcfpr_pkg::VERDICT_FRAMING;
      else if (total != crcfpr_pkg::FRAME_OVERHEAD + int'(hdr_len))
        r.verdict = crcfpr_pkg::VERDICT_LENGTH;
      else if (tail_prev != crc_acc)
        r.verdict = crcfpr_pkg::VERDICT_CRC;
      else
        r.verdict = crcfpr_pkg::VERDICT_GOOD;
      pending_results.push_back(r);
      clear_parser();
    end else begin
      if (is_pay) begin
        r.result_kind    = crcfpr_pkg::KIND_PAYLOAD;
        r.command        = hdr_cmd;
        r.payload_byte   = b;
        r.payload_index  = 16'(pos_q - crcfpr_pkg::POS_PAYLOAD);
        r.payload_length = hdr_len;
        pending_results.push_back(r);
      end
      if (pos_q != crcfpr_pkg::POS_MAX) pos_q = pos_q + 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input crcfpr_pkg::result_t got,
                                 input crcfpr_pkg::result_t want);
    string got_s;
    string want_s;
    got_s  = $sformatf("kind=%0d cmd=%02h byte=%02h idx=%0d len=%0d vrd=%0d",
                       got.result_kind, got.command, got.payload_byte,
                       got.payload_index, got.payload_length, got.verdict);
    want_s = $sformatf("kind=%0d cmd=%02h byte=%02h idx=%0d len=%0d vrd=%0d",
                       want.result_kind, want.command, want.payload_byte,
                       want.payload_index, want.payload_length, want.verdict);
    if (errors < MAX_REPORTS)
      $display("%0t ERROR %s: got %s | want %s", $time, what, got_s, want_s);
    errors++;
  endtask

  // Send one rx beat, with an optional random gap in front
  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_en ? $urandom_range(0, 12) : 0;
    repeat (gap) begin
      @(negedge clk);
      rx_valid = 1'b0;
    end
    @(negedge clk);
    rx_valid = 1'b1;
    rx_data  = '{rx_byte: b, buffer_end: last};
    do @(posedge clk); while (!rx_ready);
    predict_beat(b, last);
    sent_items++;
  endtask

  // Frame assembly: header, then payload by caller, then CRC and end mark
  task automatic start_frame(input logic [7:0] cmd, input int len);
    frame_bytes.delete();
    frame_bytes.push_back(crcfpr_pkg::START_MARK);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(cmd);
  endtask

  task automatic close_frame();
    logic [15:0] crc;
    crc = crcfpr_pkg::CRC_INIT;
    for (int i = 1; i < frame_bytes.size(); i++) crc = crc16_step(crc, frame_bytes[i]);
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crcfpr_pkg::END_MARK);
  endtask

  task automatic transmit_buffer();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Good frames at the field extremes, and short buffers
  task automatic test_good_and_short();
    start_frame(8'h00, 0);
    close_frame();
    transmit_buffer();
    start_frame(8'hFF, 2);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h00);
    close_frame();
    transmit_buffer();
    // lone end mark: too short
    send_beat(crcfpr_pkg::END_MARK, 1'b1);
    // header cut after the length bytes
    send_beat(crcfpr_pkg::START_MARK, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
  endtask

  // Bad start, CRC mismatch, length mismatch ending on a payload byte
  task automatic test_frame_errors();
    start_frame(8'h81, 1);
    frame_bytes.push_back(8'h7E);
    close_frame();
    frame_bytes[0] = 8'h00;
    transmit_buffer();
    start_frame(8'h5A, 0);
    close_frame();
    frame_bytes[4] = frame_bytes[4] ^ 8'h01;
    transmit_buffer();
    start_frame(8'h3C, 4);
    frame_bytes.push_back(8'h11);
    frame_bytes.push_back(8'h22);
    frame_bytes.push_back(crcfpr_pkg::END_MARK);
    transmit_buffer();
  endtask

  // Mostly well-formed frames with random content, some damaged, some noise
  task automatic test_random_buffers(input int n_items);
    int target;
    int kind;
    int len;
    int n;
    int idx;
    target = sent_items + n_items;
    while (sent_items < target) begin
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      start_frame(8'($urandom_range(0, 255)), len);
      repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
      close_frame();
      if (kind < 55) begin
        // left intact
      end else if (kind < 62) begin
        frame_bytes[0] = frame_bytes[0] ^ (8'h01 << $urandom_range(0, 7));
      end else if (kind < 69) begin
        idx = frame_bytes.size() - 1;
        frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
      end else if (kind < 77) begin
        idx = $urandom_range(1, frame_bytes.size() - 2);
        frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
      end else if (kind < 82) begin
        // one byte too many before the end mark
        void'(frame_bytes.pop_back());
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(crcfpr_pkg::END_MARK);
      end else if (kind < 86) begin
        // one CRC byte missing
        void'(frame_bytes.pop_back());
        void'(frame_bytes.pop_back());
        frame_bytes.push_back(crcfpr_pkg::END_MARK);
      end else if (kind < 93) begin
        n = $urandom_range(1, frame_bytes.size() - 1);
        while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
        if ($urandom_range(0, 1)) frame_bytes[n-1] = crcfpr_pkg::END_MARK;
      end else begin
        frame_bytes.delete();
        n = $urandom_range(1, 10);
        repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) frame_bytes[0] = crcfpr_pkg::START_MARK;
      end
      transmit_buffer();
    end
  endtask

  // Receiver holds off for a long stretch while frames keep coming
  task automatic test_backpressure();
    idle_en  = 1'b0;
    stall_en = 1'b0;
    hold_len = 400;
    for (int f = 0; f < 2; f++) begin
      start_frame(8'($urandom_range(0, 255)), 12 + 8 * f);
      repeat (12 + 8 * f) frame_bytes.push_back(8'($urandom_range(0, 255)));
      close_frame();
      transmit_buffer();
    end
  endtask

  // Largest header length, buffer ended far short of it
  task automatic test_long_length();
    send_beat(crcfpr_pkg::START_MARK, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hC3, 1'b0);
    for (int i = 0; i < 20; i++) send_beat(8'($urandom_range(0, 255)), 1'b0);
    send_beat(crcfpr_pkg::END_MARK, 1'b1);
  endtask

  // Result side: random ready stalls per beat, plus an optional long hold
  initial begin
    int wait_n;
    res_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      wait_n = stall_en ? $urandom_range(0, 12) : 0;
      if (hold_len != 0) begin
        wait_n   = hold_len;
        hold_len = 0;
      end
      repeat (wait_n) begin
        @(negedge clk);
        res_ready = 1'b0;
      end
      @(negedge clk);
      res_ready = 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  // Result checker
  always @(posedge clk) begin
    crcfpr_pkg::result_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", res_data, '0);
      end else begin
        want = pending_results.pop_front();
        if (res_data !== want) report_mismatch("result mismatch", res_data, want);
      end
    end
  end

  // Watchdog on cycles without any accepted beat or taken result
  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog expired, %0d results outstanding", $time,
                 pending_results.size());
        $display("tb_crc_framed_packet_receiver: FAIL");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    rst          = 1'b1;
    rx_valid     = 1'b0;
    rx_data      = '0;
    idle_en      = 1'b1;
    stall_en     = 1'b1;
    hold_len     = 0;
    errors       = 0;
    sent_items   = 0;
    clear_parser();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_good_and_short();
    test_frame_errors();
    test_random_buffers(650);
    test_backpressure();
    test_random_buffers(350);
    idle_en  = 1'b1;
    stall_en = 1'b1;
    test_random_buffers(300);
    idle_en  = 1'b0;
    stall_en = 1'b0;
    test_long_length();

    // drain
    @(negedge clk);
    rx_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("result never arrived", '0, pending_results[0]);
    if (errors == 0)
      $display("tb_crc_framed_packet_receiver: PASS");
    else
      $display("tb_crc_framed_packet_receiver: FAIL");
    $finish;
  end

endmodule
